// ===== src/ufrc_pkg.sv =====
// Shared types, sizes and helpers of the union-find engine.
// Used by the controller, the datapath and the top level; depends on nothing.
package ufrc_pkg;

    // Table size and field widths
    localparam int NODES    = 1024;
    localparam int NODE_W   = $clog2(NODES);
    localparam int FIELD_W  = 10;
    localparam int RANK_W   = 4;
    localparam int RANK_MAX = 15;

    typedef logic [NODE_W-1:0]  node_t;
    typedef logic [FIELD_W-1:0] field_t;
    typedef logic [RANK_W-1:0]  rank_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear_step;  // write one reset entry, advance the sweep
        logic start_a;     // capture the transaction, start walking from node_a
        logic start_b;     // start walking from node_b
        logic walk;        // follow one parent link
        logic root_take;   // latch the root, restart at the path start
        logic compress;    // point one path node at the root, advance
        logic link;        // join the two roots
        logic result;      // load the output register
        logic phase_b;     // walk in progress belongs to node_b
    } ufrc_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clr_last;    // sweep at the last entry
        logic root_found;  // node read points at itself
        logic at_top;      // compression reached the root
        logic is_union;    // captured operation is a union
        logic out_free;    // output register can take a result
    } ufrc_sts_t;

    // Reduce a node field modulo NODES by binary long division
    function automatic node_t node_reduce(input field_t raw);
        logic [31:0] rem;
        rem = 32'(raw);
        for (int k = FIELD_W - 1; k >= 0; k--) begin
            if (rem >= (32'(NODES) << k)) begin
                rem = rem - (32'(NODES) << k);
            end
        end
        return NODE_W'(rem);
    endfunction

    // Fit a node index into the result field
    function automatic field_t root_field(input node_t n);
        logic [31:0] wide;
        wide = 32'(n);
        return wide[FIELD_W-1:0];
    endfunction

endpackage

// ===== src/ufrc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; used for the parent and rank tables.
module ufrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, then register the read data
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ufrc_ctrl.sv =====
// Controller of the union-find engine: sequences clear, walk, compress, link, result.
// Depends on ufrc_pkg; drives the datapath through ufrc_cmd_t.
module ufrc_ctrl import ufrc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ufrc_sts_t sts,
    output ufrc_cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_CLEAR    = 6'b000001,
        ST_IDLE     = 6'b000010,
        ST_WALK     = 6'b000100,
        ST_COMPRESS = 6'b001000,
        ST_LINK     = 6'b010000,
        ST_RESULT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   phase_b_reg, phase_b_next;

    // Hold state and walk phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            phase_b_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_b_reg <= phase_b_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    // Decode the next state and the datapath commands
    always_comb begin
        cmd          = '0;
        cmd.phase_b  = phase_b_reg;
        state_next   = state_reg;
        phase_b_next = phase_b_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.start_a  = 1'b1;
                    phase_b_next = 1'b0;
                    state_next   = ST_WALK;
                end
            end
            ST_WALK: begin
                if (sts.root_found) begin
                    cmd.root_take = 1'b1;
                    state_next    = ST_COMPRESS;
                end else begin
                    cmd.walk = 1'b1;
                end
            end
            ST_COMPRESS: begin
                if (!sts.at_top) begin
                    cmd.compress = 1'b1;
                end else if (sts.is_union && !phase_b_reg) begin
                    cmd.start_b  = 1'b1;
                    phase_b_next = 1'b1;
                    state_next   = ST_WALK;
                end else if (sts.is_union) begin
                    state_next = ST_LINK;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_LINK: begin
                cmd.link   = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (sts.out_free) begin
                    cmd.result = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The clearing sweep runs once after reset
    a_clear_once: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_CLEAR |=> state_reg != ST_CLEAR)
        else $error("clearing sweep re-entered");

    // An accepted transaction starts a walk
    a_accept_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_WALK && !phase_b_reg)
        else $error("accepted transaction did not start a walk");

    // Linking follows both walks of a union
    a_link_union: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LINK |-> sts.is_union && phase_b_reg)
        else $error("link without two finished walks");

endmodule

// ===== src/ufrc_dp.sv =====
// Datapath of the union-find engine: parent and rank tables, walk registers, output register.
// Depends on ufrc_pkg and ufrc_ram; commanded by ufrc_ctrl.
module ufrc_dp import ufrc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  ufrc_cmd_t cmd,
    output ufrc_sts_t sts,
    input  logic      s_operation,
    input  field_t    s_node_a,
    input  field_t    s_node_b,
    output logic      m_valid,
    input  logic      m_ready,
    output field_t    m_root,
    output logic      m_already_joined
);

    logic  op_reg;
    node_t node_b_reg, start_reg, cur_reg, top_reg, ra_reg, rb_reg, clr_reg;
    rank_t rank_ra_reg, rank_rb_reg;
    logic  m_valid_reg, m_joined_reg;
    field_t m_root_reg;

    node_t node_a_in, node_b_in;
    node_t raddr, par_waddr, par_wdata, par_rdata, rank_waddr;
    logic  par_we, rank_we;
    rank_t rank_wdata, rank_rdata;
    logic  joined, pick_a;

    assign node_a_in = node_reduce(s_node_a);
    assign node_b_in = node_reduce(s_node_b);

    // Result of the current transaction
    assign joined = op_reg && (ra_reg == rb_reg);
    assign pick_a = !op_reg || joined || (rank_ra_reg > rank_rb_reg);

    // Select the table read address
    always_comb begin
        raddr = cur_reg;
        if (cmd.start_a) begin
            raddr = node_a_in;
        end else if (cmd.start_b) begin
            raddr = node_b_reg;
        end else if (cmd.walk || cmd.compress) begin
            raddr = par_rdata;
        end else if (cmd.root_take) begin
            raddr = start_reg;
        end
    end

    // Drive the table writes: sweep, compression, link
    always_comb begin
        par_we     = 1'b0;
        par_waddr  = cur_reg;
        par_wdata  = top_reg;
        rank_we    = 1'b0;
        rank_waddr = rb_reg;
        rank_wdata = rank_t'(rank_rb_reg + 1'b1);
        if (cmd.clear_step) begin
            par_we     = 1'b1;
            par_waddr  = clr_reg;
            par_wdata  = clr_reg;
            rank_we    = 1'b1;
            rank_waddr = clr_reg;
            rank_wdata = '0;
        end else if (cmd.compress) begin
            par_we = 1'b1;
        end else if (cmd.link && (ra_reg != rb_reg)) begin
            par_we = 1'b1;
            if (rank_ra_reg > rank_rb_reg) begin
                par_waddr = rb_reg;
                par_wdata = ra_reg;
            end else begin
                par_waddr = ra_reg;
                par_wdata = rb_reg;
                rank_we   = (rank_ra_reg == rank_rb_reg) &&
                            (rank_rb_reg != rank_t'(RANK_MAX));
            end
        end
    end

    ufrc_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_parent (
        .aclk  (aclk),
        .we    (par_we),
        .waddr (par_waddr),
        .wdata (par_wdata),
        .raddr (raddr),
        .rdata (par_rdata)
    );

    ufrc_ram #(.WIDTH(RANK_W), .DEPTH(NODES)) u_rank (
        .aclk  (aclk),
        .we    (rank_we),
        .waddr (rank_waddr),
        .wdata (rank_wdata),
        .raddr (raddr),
        .rdata (rank_rdata)
    );

    // Control registers: sweep counter and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clear_step) begin
                clr_reg <= node_t'(clr_reg + 1'b1);
            end
            if (cmd.result) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Walk and payload registers
    always_ff @(posedge aclk) begin
        if (cmd.start_a) begin
            op_reg     <= s_operation;
            node_b_reg <= node_b_in;
            start_reg  <= node_a_in;
            cur_reg    <= node_a_in;
        end
        if (cmd.start_b) begin
            start_reg <= node_b_reg;
            cur_reg   <= node_b_reg;
        end
        if (cmd.walk || cmd.compress) begin
            cur_reg <= par_rdata;
        end
        if (cmd.root_take) begin
            top_reg <= cur_reg;
            cur_reg <= start_reg;
            if (cmd.phase_b) begin
                rb_reg      <= cur_reg;
                rank_rb_reg <= rank_rdata;
            end else begin
                ra_reg      <= cur_reg;
                rank_ra_reg <= rank_rdata;
            end
        end
        if (cmd.result) begin
            m_root_reg   <= root_field(pick_a ? ra_reg : rb_reg);
            m_joined_reg <= joined;
        end
    end

    assign sts.clr_last   = (clr_reg == node_t'(NODES - 1));
    assign sts.root_found = (par_rdata == cur_reg);
    assign sts.at_top     = (cur_reg == top_reg);
    assign sts.is_union   = op_reg;
    assign sts.out_free   = !m_valid_reg || m_ready;

    assign m_valid          = m_valid_reg;
    assign m_root           = m_root_reg;
    assign m_already_joined = m_joined_reg;

    // Compression never rewrites the root itself
    a_root_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.compress |-> par_waddr != top_reg)
        else $error("compression wrote the root entry");

    // Linking two distinct roots hangs one under the other
    a_link_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.link && (ra_reg != rb_reg) |-> par_we && (par_waddr != par_wdata))
        else $error("link of distinct roots left both as roots");

    // Hold a waiting result until it is taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_root) && $stable(m_already_joined))
        else $error("waiting result changed before it was taken");

endmodule

// ===== src/union_find_rank_compress.sv =====
// Top level of the union-find engine with path compression and union by rank.
// Depends on ufrc_pkg, ufrc_ctrl, ufrc_dp (which holds two ufrc_ram tables).
//
// One transaction at a time. After reset the block sweeps both tables (every
// node made its own root, all ranks zero) and holds s_ready low until the
// sweep ends. A find walks up the parent table from the node to its root, then
// makes a compression pass over the same path that points each node on it at
// the root, both through the table's single read port, and then loads the
// output register. A union walks and compresses for both nodes, then links the
// two roots. Compression keeps the paths short. A finished result waits in the
// output register while the next transaction is accepted; a new result waits
// until the output register is free or its result is being taken.
module union_find_rank_compress import ufrc_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  logic   s_operation,
    input  field_t s_node_a,
    input  field_t s_node_b,
    output logic   m_valid,
    input  logic   m_ready,
    output field_t m_root,
    output logic   m_already_joined
);

    ufrc_cmd_t cmd;
    ufrc_sts_t sts;

    ufrc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ufrc_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .s_operation      (s_operation),
        .s_node_a         (s_node_a),
        .s_node_b         (s_node_b),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_root           (m_root),
        .m_already_joined (m_already_joined)
    );

endmodule
